// ===== hw/rtl/bped_pkg.sv =====
`timescale 1ns / 1ps

package bped_pkg;

  // Width of the debounce, hold and repeat counters and of the timing registers.
  localparam int unsigned CntW = 8;

  // Hold count at which the count is folded back to the long-press threshold.
  localparam logic [CntW-1:0] HoldTop = 8'hFF;

  // Depth of the result word queue.
  localparam int unsigned EvqDepth = 4;
  localparam int unsigned EvqPtrW  = $clog2(EvqDepth);
  localparam int unsigned EvqCntW  = $clog2(EvqDepth + 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ACTIVE_LEVEL  = 2'd0,
    REG_DEBOUNCE      = 2'd1,
    REG_LONG_PRESS    = 2'd2,
    REG_REPEAT        = 2'd3
  } reg_idx_e;

  // Press machine states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DOWN = 2'd1,
    ST_UP   = 2'd2
  } press_state_e;

  // Kind of press recorded so far.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_LONG = 2'd2
  } kind_e;

  // Reported events.
  typedef enum logic [1:0] {
    EV_RELEASED      = 2'd0,
    EV_CLICK         = 2'd1,
    EV_LONG_REPEAT   = 2'd2,
    EV_LONG_RELEASED = 2'd3
  } event_e;

  // Configuration registers as seen by the detector core.
  typedef struct packed {
    logic            active_level;
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] repeat_ticks;
  } cfg_t;

  // Up to two events caused by one tick, in order.
  typedef struct packed {
    logic [1:0] num;
    event_e     ev0;
    event_e     ev1;
  } ev_pair_t;

  // One result word as held in the queue.
  typedef struct packed {
    event_e ev;
    logic   last;
  } ev_word_t;

endpackage

// ===== hw/rtl/bped_core.sv =====
`timescale 1ns / 1ps

module bped_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              pin_level_i,
  input  bped_pkg::cfg_t    cfg_i,
  output bped_pkg::ev_pair_t evs_o
);

  import bped_pkg::*;

  press_state_e    state_q, state_d, mid_state;
  logic            stable_q, stable_d;
  logic [CntW-1:0] bounce_q, bounce_d, bounce_inc;
  logic [CntW-1:0] hold_q, hold_d, hold_inc;
  logic [CntW-1:0] rep_q, rep_d, rep_inc;
  kind_e           cur_q, cur_d, prev_q, prev_d, kind_w;
  logic            lvl_chg, take, rel_vld, evb_vld;
  event_e          evb;

  // State register; it moves only when a tick is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stable_q <= 1'b1;
      bounce_q <= '0;
      hold_q   <= '0;
      rep_q    <= '0;
      cur_q    <= KIND_NONE;
      prev_q   <= KIND_NONE;
    end else if (step_i) begin
      state_q  <= state_d;
      stable_q <= stable_d;
      bounce_q <= bounce_d;
      hold_q   <= hold_d;
      rep_q    <= rep_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
    end
  end

  // Debounce, then the press machine acting on the newly accepted level.
  always_comb begin
    bounce_inc = bounce_q + 8'd1;
    hold_inc   = hold_q + 8'd1;
    rep_inc    = rep_q + 8'd1;
    lvl_chg    = (pin_level_i != stable_q);
    take       = lvl_chg && (bounce_inc >= cfg_i.debounce_ticks);

    stable_d  = stable_q;
    bounce_d  = bounce_q;
    hold_d    = hold_q;
    rep_d     = rep_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    kind_w    = cur_q;
    rel_vld   = 1'b0;
    evb_vld   = 1'b0;
    evb       = EV_CLICK;
    mid_state = state_q;

    // The count only grows while the sample differs; bounces leave it alone.
    if (lvl_chg) begin
      bounce_d = take ? '0 : bounce_inc;
      if (take) begin
        stable_d = pin_level_i;
      end
    end

    // An accepted change starts a press, or ends one with a release.
    if (take) begin
      unique case (state_q)
        ST_IDLE: begin
          mid_state = ST_DOWN;
        end
        ST_DOWN: begin
          mid_state = ST_UP;
          rel_vld   = 1'b1;
        end
        default: ;
      endcase
    end
    state_d = mid_state;

    unique case (mid_state)
      ST_DOWN: begin
        if (stable_d == cfg_i.active_level) begin
          kind_w = KIND_DOWN;
          hold_d = hold_inc;
          if (hold_inc >= cfg_i.long_press_ticks) begin
            rep_d = rep_inc;
            if (rep_inc >= cfg_i.repeat_ticks) begin
              rep_d   = '0;
              kind_w  = KIND_LONG;
              evb_vld = 1'b1;
              evb     = EV_LONG_REPEAT;
            end
            if (hold_inc == HoldTop) begin
              hold_d = cfg_i.long_press_ticks;
            end
          end
          if (prev_q == KIND_LONG) begin
            kind_w = KIND_LONG;
          end
          cur_d  = kind_w;
          prev_d = kind_w;
        end
      end
      ST_UP: begin
        // With no kind recorded the machine stays here.
        if (cur_q == KIND_DOWN) begin
          evb_vld = 1'b1;
          evb     = EV_CLICK;
          hold_d  = '0;
          state_d = ST_IDLE;
        end else if (cur_q == KIND_LONG) begin
          evb_vld = 1'b1;
          evb     = EV_LONG_RELEASED;
          hold_d  = '0;
          state_d = ST_IDLE;
        end
        prev_d = KIND_DOWN;
      end
      default: ;
    endcase
  end

  // A release always comes first when a tick causes two events.
  always_comb begin
    evs_o.num = {1'b0, rel_vld} + {1'b0, evb_vld};
    evs_o.ev0 = rel_vld ? EV_RELEASED : evb;
    evs_o.ev1 = evb;
  end

endmodule

// ===== hw/rtl/bped_evq.sv =====
`timescale 1ns / 1ps

module bped_evq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bped_pkg::ev_pair_t evs_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bped_pkg::event_e   event_res_o,
  output logic               last_o
);

  import bped_pkg::*;

  ev_word_t               mem_q [EvqDepth];
  logic [EvqPtrW-1:0]     wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [EvqCntW-1:0]     cnt_q, cnt_d;
  logic [1:0]             push_num;
  logic                   pop;

  // Two free places are needed so that any tick can be taken.
  assign room_o   = (cnt_q <= EvqCntW'(EvqDepth - 2));
  assign push_num = push_i ? evs_i.num : 2'd0;
  assign pop      = (cnt_q != '0) && !out_stall_i;
  assign wr_nxt   = wr_q + EvqPtrW'(1);

  // Pointer and fill count arithmetic.
  always_comb begin
    wr_d  = wr_q + EvqPtrW'(push_num);
    rd_d  = pop ? rd_q + EvqPtrW'(1) : rd_q;
    cnt_d = cnt_q + EvqCntW'(push_num) - EvqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Word storage; the second word of a pair carries the last mark.
  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      mem_q[wr_q] <= '{ev: evs_i.ev0, last: (push_num == 2'd1)};
    end
    if (push_num == 2'd2) begin
      mem_q[wr_nxt] <= '{ev: evs_i.ev1, last: 1'b1};
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign event_res_o = mem_q[rd_q].ev;
  assign last_o      = mem_q[rd_q].last;

endmodule

// ===== hw/rtl/button_press_event_detector.sv =====
`timescale 1ns / 1ps
// A tick in the input register is processed once the queue has room; its words go into the queue.
// Throughput: one tick per cycle into the input register unless it stalls; the output delivers
// one word per cycle unless stalled, and a four-word queue absorbs ticks that cause two events.
// The input stalls only while that queue holds more than two words.
// Reset is asynchronous and active low; it clears control state and loads the register defaults.
module button_press_event_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       pin_level_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  import bped_pkg::*;

  cfg_t     cfg_q;
  logic     in_valid_q, pin_q;
  logic     room, step, in_acc;
  ev_pair_t evs;
  event_e   ev_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level     <= 1'b0;
      cfg_q.debounce_ticks   <= 8'd3;
      cfg_q.long_press_ticks <= 8'd50;
      cfg_q.repeat_ticks     <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ACTIVE_LEVEL: cfg_q.active_level     <= cfg_data_i[0];
        REG_DEBOUNCE:     cfg_q.debounce_ticks   <= cfg_data_i;
        REG_LONG_PRESS:   cfg_q.long_press_ticks <= cfg_data_i;
        REG_REPEAT:       cfg_q.repeat_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register; a held tick is processed as soon as the queue has room.
  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pin_q <= pin_level_i;
    end
  end

  bped_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_level_i (pin_q),
    .cfg_i       (cfg_q),
    .evs_o       (evs)
  );

  bped_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .evs_i       (evs),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (ev_out),
    .last_o      (last_o)
  );

  assign event_res_o = ev_out;

endmodule

// ===== hw/rtl/bped_checker.sv =====
`timescale 1ns / 1ps

module bped_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_res_o,
  input logic       last_o
);

  import bped_pkg::*;

  // A stalled word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) && $stable(last_o))
    else $error("stalled output word changed");

  // Only a release can be followed by another word of the same tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != EV_RELEASED) |-> last_o)
    else $error("non-release word without last mark");

  // A word that is not last is followed at once by a click or a long-press release.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=>
      out_valid_o && (event_res_o == EV_CLICK || event_res_o == EV_LONG_RELEASED))
    else $error("second word of a pair missing or wrong");

  // The input only backs up behind pending output words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind button_press_event_detector bped_checker u_bped_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o),
  .last_o      (last_o)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bped_pkg::*;

  localparam int unsigned QuietLimit = 4000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       pin_level_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] event_res_o;
  logic       last_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = 2'd0;
  logic [7:0] cfg_data_i = 8'd0;

  // Percentages of cycles in which the tick source and the event sink hold back.
  int send_idle_pct = 28;
  int recv_idle_pct = 64;

  int err_count = 0;
  int ticks_sent = 0;
  int quiet_cycles = 0;

  // Event words still owed by the block, oldest first.
  ev_word_t pending_events[$];

  // Local copy of the detector registers and state.
  logic            cfg_active;
  logic [CntW-1:0] cfg_debounce;
  logic [CntW-1:0] cfg_long;
  logic [CntW-1:0] cfg_repeat;
  press_state_e    pm_state;
  logic            lvl_stable;
  logic [CntW-1:0] cnt_bounce;
  logic [CntW-1:0] cnt_hold;
  logic [CntW-1:0] cnt_repeat;
  kind_e           kind_now;
  kind_e           kind_prev;

  button_press_event_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pin_level_i (pin_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic log_failure(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Works out the events that one scan tick causes and queues them in order.
  function automatic void predict_events(input logic lvl);
    event_e   evs [2];
    ev_word_t w;
    int       n;
    n = 0;
    // Debounce: only differing samples advance the count.
    if (lvl != lvl_stable) begin
      cnt_bounce = cnt_bounce + 1'b1;
      if (cnt_bounce >= cfg_debounce) begin
        lvl_stable = lvl;
        cnt_bounce = '0;
        if (pm_state == ST_IDLE) begin
          pm_state = ST_DOWN;
        end else if (pm_state == ST_DOWN) begin
          pm_state = ST_UP;
          evs[n] = EV_RELEASED;
          n++;
        end
      end
    end
    // Press machine.
    if (pm_state == ST_DOWN) begin
      if (lvl_stable == cfg_active) begin
        kind_now = KIND_DOWN;
        cnt_hold = cnt_hold + 1'b1;
        if (cnt_hold >= cfg_long) begin
          cnt_repeat = cnt_repeat + 1'b1;
          if (cnt_repeat >= cfg_repeat) begin
            cnt_repeat = '0;
            kind_now = KIND_LONG;
            evs[n] = EV_LONG_REPEAT;
            n++;
          end
          if (cnt_hold == HoldTop) begin
            cnt_hold = cfg_long;
          end
        end
        if (kind_prev == KIND_LONG) begin
          kind_now = KIND_LONG;
        end
        kind_prev = kind_now;
      end
    end else if (pm_state == ST_UP) begin
      if (kind_now == KIND_DOWN) begin
        evs[n] = EV_CLICK;
        n++;
        cnt_hold = '0;
        pm_state = ST_IDLE;
      end else if (kind_now == KIND_LONG) begin
        evs[n] = EV_LONG_RELEASED;
        n++;
        cnt_hold = '0;
        pm_state = ST_IDLE;
      end
      kind_prev = KIND_DOWN;
    end
    for (int i = 0; i < n; i++) begin
      w.ev = evs[i];
      w.last = (i == n - 1);
      pending_events.push_back(w);
    end
  endfunction

  // Offers one tick, holds it through any stall and predicts it once taken.
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    predict_events(lvl);
    ticks_sent++;
  endtask

  // Waits until every owed word has arrived and the pipeline has emptied.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all four registers; spare data bits of the level register carry junk.
  task automatic write_registers(input logic act, input logic [7:0] deb,
                                 input logic [7:0] lp, input logic [7:0] rp);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_ACTIVE_LEVEL;
    cfg_data_i <= {junk[6:0], act};
    @(negedge clk_i);
    cfg_index_i <= REG_DEBOUNCE;
    cfg_data_i <= deb;
    @(negedge clk_i);
    cfg_index_i <= REG_LONG_PRESS;
    cfg_data_i <= lp;
    @(negedge clk_i);
    cfg_index_i <= REG_REPEAT;
    cfg_data_i <= rp;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_active = act;
    cfg_debounce = deb;
    cfg_long = lp;
    cfg_repeat = rp;
  endtask

  // One press: the active level long enough to be accepted and held, then the
  // inactive level; each sample may be flipped to act as contact bounce.
  task automatic press_sequence(input int hold_len, input int gap_len, input int glitch_pct);
    logic act;
    act = cfg_active;
    for (int i = 0; i < cfg_debounce + hold_len; i++) begin
      send_tick(($urandom_range(99) < glitch_pct) ? ~act : act);
    end
    for (int i = 0; i < cfg_debounce + gap_len; i++) begin
      send_tick(($urandom_range(99) < glitch_pct) ? act : ~act);
    end
  endtask

  // Reset values, with bounces that must not clear the debounce count, then a click.
  task automatic test_reset_click();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Smallest timings: a repeat on every held tick and a release that yields two words.
  task automatic test_fast_repeat();
    drain_pipeline();
    write_registers(1'b0, 8'd1, 8'd1, 8'd1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Active level high: the press machine enters down with the pin inactive and
  // reports the kind left from the previous press when it is released.
  task automatic test_active_high();
    drain_pipeline();
    write_registers(1'b1, 8'd1, 8'd1, 8'd1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Mostly well-formed presses with random timing, mixed with random pin noise.
  task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_ticks);
    int stop_at;
    int hold_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int part = 0; part < 2; part++) begin
      drain_pipeline();
      write_registers(($urandom_range(99) < 25), 8'($urandom_range(1, 6)),
                      8'($urandom_range(1, 20)), 8'($urandom_range(1, 8)));
      stop_at = ticks_sent + n_ticks / 2;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(99) < 75) begin
          hold_len = $urandom_range(0, cfg_long + 3 * cfg_repeat);
          press_sequence(hold_len, $urandom_range(0, 6), ($urandom_range(1) ? 8 : 0));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
        end
      end
    end
  endtask

  // Hold threshold 254 and the longest repeat timing, held long enough for the hold count to fold back.
  task automatic test_long_hold();
    drain_pipeline();
    write_registers(1'b0, 8'd2, 8'd254, 8'd255);
    press_sequence(512, 4, 0);
  endtask

  // The sink stalls at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Each accepted word is compared with the oldest one owed.
  always @(posedge clk_i) begin : check_words
    ev_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        log_failure($sformatf("unexpected word ev=%0d last=%0b", event_res_o, last_o));
      end else begin
        want = pending_events.pop_front();
        if (event_res_o !== want.ev || last_o !== want.last) begin
          log_failure($sformatf("expected ev=%0d last=%0b, got ev=%0d last=%0b",
                                want.ev, want.last, event_res_o, last_o));
        end
      end
    end
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_active = 1'b0;
    cfg_debounce = 8'd3;
    cfg_long = 8'd50;
    cfg_repeat = 8'd10;
    pm_state = ST_IDLE;
    lvl_stable = 1'b1;
    cnt_bounce = '0;
    cnt_hold = '0;
    cnt_repeat = '0;
    kind_now = KIND_NONE;
    kind_prev = KIND_NONE;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_click();
    test_fast_repeat();
    test_active_high();
    test_random_phase(28, 64, 100);
    test_random_phase(64, 28, 100);
    test_random_phase(0, 0, 100);
    test_long_hold();

    drain_pipeline();
    repeat (8) @(negedge clk_i);
    if (pending_events.size() != 0) begin
      log_failure($sformatf("%0d words never arrived", pending_events.size()));
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== button_press_event_detector.f =====
hw/rtl/bped_pkg.sv
hw/rtl/bped_core.sv
hw/rtl/bped_evq.sv
hw/rtl/button_press_event_detector.sv
hw/rtl/bped_checker.sv
bench/tb_top.sv
